// ===== sv/block_owner_allocator_top_defines.svh =====
// Assertion macros shared by the block owner allocator RTL files.
`ifndef BLOCK_OWNER_ALLOCATOR_TOP_DEFINES_SVH
`define BLOCK_OWNER_ALLOCATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

`define BOA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define BOA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define BOA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/boa_pkg.sv =====
// Types and constants shared by the block owner allocator modules.
`timescale 1ns / 1ps

package boa_pkg;

    localparam int OP_W      = 2;
    localparam int ID_W      = 8;
    localparam int CNT_W     = 6;
    localparam int STS_W     = 2;
    localparam int BLK_W     = 5;
    localparam int FREED_W   = 6;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int REQ_LIMIT = 32;
    localparam int FREED_MAX = 63;
    localparam int CFG_RESET = 32;

    localparam logic [OP_W-1:0] OP_CONTIG  = 2'd0;
    localparam logic [OP_W-1:0] OP_SCATTER = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

    typedef enum logic [STS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_SHORT    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_CONT_SCAN,
        CS_CONT_EMIT,
        CS_SCAT_COUNT,
        CS_SCAT_EMIT,
        CS_FREE_SCAN,
        CS_FREE_DRAIN,
        CS_SINGLE
    } ctl_state_t;

    typedef struct packed {
        logic    load;
        logic    idx_clr;
        logic    idx_inc;
        logic    idx_seek;
        logic    run_step;
        logic    cnt_step;
        logic    alloc;
        logic    rd_issue;
        logic    k_inc;
        logic    emit;
        logic    emit_blk;
        logic    last;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_zero;
        logic            idx_end;
        logic            idx_full;
        logic            blk_free;
        logic            run_hit;
        logic            take_zero;
        logic            short_fall;
        logic            k_last_cnt;
        logic            k_last_take;
        logic            out_room;
    } dp_sts_t;

endpackage

// ===== sv/block_owner_allocator_top.sv =====
// Top level of the block owner allocator: configuration register, controller and datapath.
// Contiguous allocate finds the first fitting run and then allocates count blocks; scattered
// allocate counts the free managed blocks and then takes up to count of them; free scans all
// NUM_BLOCKS blocks. The table scan runs at one block per cycle while the output has room.
// One operation is in flight at a time; the next beat is taken in the cycle after the last
// result is queued. Reset clears every used bit at once; the owner memory needs no clearing pass.
`timescale 1ns / 1ps

module block_owner_allocator_top #(
    parameter int NUM_BLOCKS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] opcode, [9:2] file_id, [15:10] block_count
    input  logic [boa_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [6:2] block_number, [12:7] freed_count, [15:13] zero
    output logic [boa_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [boa_pkg::CNT_W-1:0]     cfg_data
);
    import boa_pkg::*;

    logic [CNT_W-1:0] blocks_in_use_reg;
    dp_cmd_t          cmd;
    dp_sts_t          sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= CNT_W'(CFG_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            blocks_in_use_reg <= cfg_data;
        end
    end

    boa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    boa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_data       (s_tdata),
        .blocks_in_use (blocks_in_use_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

// ===== sv/boa_ctrl.sv =====
// Controller state machine that sequences the block table scans.
`timescale 1ns / 1ps
`include "block_owner_allocator_top_defines.svh"

module boa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  boa_pkg::dp_sts_t sts,
    output boa_pkg::dp_cmd_t cmd
);
    import boa_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    status_t    code_reg;
    status_t    code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = CS_DISPATCH;
                end
            end
            CS_DISPATCH:
            begin
                if (sts.op == OP_FREE)
                begin
                    state_next = CS_FREE_SCAN;
                end
                else if (sts.op != OP_CONTIG && sts.op != OP_SCATTER)
                begin
                    state_next = CS_IDLE;
                end
                else if (sts.cnt_zero)
                begin
                    state_next = CS_SINGLE;
                    code_next  = ST_OK;
                end
                else if (sts.op == OP_CONTIG)
                begin
                    state_next = CS_CONT_SCAN;
                end
                else
                begin
                    state_next = CS_SCAT_COUNT;
                end
            end
            CS_CONT_SCAN:
            begin
                if (sts.idx_end)
                begin
                    state_next = CS_SINGLE;
                    code_next  = ST_NO_SPACE;
                end
                else if (sts.run_hit)
                begin
                    state_next = CS_CONT_EMIT;
                end
            end
            CS_CONT_EMIT:
            begin
                if (sts.out_room && sts.k_last_cnt)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_SCAT_COUNT:
            begin
                if (sts.idx_end)
                begin
                    if (sts.take_zero)
                    begin
                        state_next = CS_SINGLE;
                        code_next  = ST_SHORT;
                    end
                    else
                    begin
                        state_next = CS_SCAT_EMIT;
                    end
                end
            end
            CS_SCAT_EMIT:
            begin
                if (sts.blk_free && sts.out_room && sts.k_last_take)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_FREE_SCAN:
            begin
                if (sts.idx_full)
                begin
                    state_next = CS_FREE_DRAIN;
                end
            end
            CS_FREE_DRAIN:
            begin
                state_next = CS_SINGLE;
                code_next  = ST_OK;
            end
            CS_SINGLE:
            begin
                if (sts.out_room)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.code = ST_OK;
        s_tready = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            CS_DISPATCH:
            begin
                cmd.idx_clr = 1'b1;
            end
            CS_CONT_SCAN:
            begin
                if (!sts.idx_end)
                begin
                    if (sts.run_hit)
                    begin
                        cmd.idx_seek = 1'b1;
                    end
                    else
                    begin
                        cmd.run_step = 1'b1;
                        cmd.idx_inc  = 1'b1;
                    end
                end
            end
            CS_CONT_EMIT:
            begin
                if (sts.out_room)
                begin
                    cmd.alloc    = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.emit_blk = 1'b1;
                    cmd.last     = sts.k_last_cnt;
                    cmd.idx_inc  = 1'b1;
                    cmd.k_inc    = 1'b1;
                end
            end
            CS_SCAT_COUNT:
            begin
                if (sts.idx_end)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else
                begin
                    cmd.cnt_step = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            CS_SCAT_EMIT:
            begin
                if (sts.blk_free)
                begin
                    if (sts.out_room)
                    begin
                        cmd.alloc    = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.emit_blk = 1'b1;
                        cmd.last     = sts.k_last_take;
                        cmd.code     = sts.short_fall ? ST_SHORT : ST_OK;
                        cmd.idx_inc  = 1'b1;
                        cmd.k_inc    = 1'b1;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            CS_FREE_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            CS_FREE_DRAIN:
            begin
                cmd.idx_clr = 1'b1;
            end
            CS_SINGLE:
            begin
                if (sts.out_room)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    cmd.code = code_reg;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Enough free blocks were counted, so the allocation pass never runs off the end.
    `BOA_ASSERT_IMP(a_scat_in_range, clk, rst_n, state_reg == CS_SCAT_EMIT, !sts.idx_end)
    `BOA_ASSERT_NXT(a_last_to_idle, clk, rst_n, cmd.emit && cmd.last, state_reg == CS_IDLE)
    `BOA_ASSERT_IMP(a_ready_only_idle, clk, rst_n, s_tready, state_reg == CS_IDLE)

endmodule

// ===== sv/boa_datapath.sv =====
// Datapath: block used bits, owner memory, scan counters and the result register.
`timescale 1ns / 1ps
`include "block_owner_allocator_top_defines.svh"

module boa_datapath #(
    parameter int NUM_BLOCKS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  boa_pkg::dp_cmd_t               cmd,
    output boa_pkg::dp_sts_t               sts,
    input  logic [boa_pkg::IN_W-1:0]       in_data,
    input  logic [boa_pkg::CNT_W-1:0]      blocks_in_use,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [boa_pkg::OUT_W-1:0]      m_tdata,
    output logic                           m_tlast
);
    import boa_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int IW = $clog2(NUM_BLOCKS + 1);
    localparam int XW = ((IW > CNT_W) ? IW : CNT_W) + 1;
    localparam int PAD_W = OUT_W - STS_W - BLK_W - FREED_W;

    logic [OP_W-1:0]       op_reg;
    logic [ID_W-1:0]       id_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [IW-1:0]         n_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         idx_next;
    logic [CNT_W-1:0]      run_reg;
    logic [CNT_W-1:0]      run_next;
    logic [CNT_W-1:0]      k_reg;
    logic [CNT_W-1:0]      k_next;
    logic [IW-1:0]         fcnt_reg;
    logic [IW-1:0]         fcnt_next;
    logic [IW-1:0]         freed_reg;
    logic [IW-1:0]         freed_next;
    logic [NUM_BLOCKS-1:0] used_reg;
    logic [ID_W-1:0]       owner_mem [NUM_BLOCKS];
    logic                  rd_valid_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic [ID_W-1:0]       rd_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               out_status_reg;
    logic [BLK_W-1:0]      out_block_reg;
    logic [FREED_W-1:0]    out_freed_reg;
    logic                  out_last_reg;

    logic [OP_W-1:0]       in_op;
    logic [ID_W-1:0]       in_id;
    logic [CNT_W-1:0]      in_cnt;
    logic [CNT_W-1:0]      cnt_clamp;
    logic [IW-1:0]         n_sel;
    logic [AW-1:0]         addr;
    logic                  blk_free;
    logic                  short_fall;
    logic [CNT_W-1:0]      take;
    logic [IW-1:0]         seek;
    logic [FREED_W-1:0]    freed_sat;
    logic                  free_hit;
    logic                  out_room;

    assign in_op  = in_data[OP_W-1:0];
    assign in_id  = in_data[OP_W+ID_W-1:OP_W];
    assign in_cnt = in_data[OP_W+ID_W+CNT_W-1:OP_W+ID_W];

    assign cnt_clamp = (in_cnt > CNT_W'(REQ_LIMIT)) ? CNT_W'(REQ_LIMIT) : in_cnt;
    assign n_sel = (XW'(blocks_in_use) < XW'(NUM_BLOCKS)) ? IW'(blocks_in_use)
                                                          : IW'(NUM_BLOCKS);

    assign addr     = idx_reg[AW-1:0];
    assign blk_free = !used_reg[addr];

    assign short_fall = XW'(fcnt_reg) < XW'(cnt_reg);
    assign take       = short_fall ? CNT_W'(fcnt_reg) : cnt_reg;

    // The run that just completed ends at idx, so it starts count-1 blocks back.
    assign seek = IW'(XW'(idx_reg) + XW'(1) - XW'(cnt_reg));

    assign freed_sat = (XW'(freed_reg) > XW'(FREED_MAX)) ? FREED_W'(FREED_MAX)
                                                         : FREED_W'(freed_reg);
    assign free_hit  = rd_valid_reg && used_reg[rd_idx_reg] && (rd_data_reg == id_reg);
    assign out_room  = !out_valid_reg || m_tready;

    always_comb
    begin
        sts             = '0;
        sts.op          = op_reg;
        sts.cnt_zero    = (cnt_reg == '0);
        sts.idx_end     = (idx_reg == n_reg);
        sts.idx_full    = (idx_reg == IW'(NUM_BLOCKS - 1));
        sts.blk_free    = blk_free;
        sts.run_hit     = blk_free && ((run_reg + CNT_W'(1)) == cnt_reg);
        sts.take_zero   = (take == '0);
        sts.short_fall  = short_fall;
        sts.k_last_cnt  = ((k_reg + CNT_W'(1)) == cnt_reg);
        sts.k_last_take = ((k_reg + CNT_W'(1)) == take);
        sts.out_room    = out_room;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load || cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_seek)
        begin
            idx_next = seek;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IW'(1);
        end

        run_next = run_reg;
        if (cmd.load)
        begin
            run_next = '0;
        end
        else if (cmd.run_step)
        begin
            run_next = blk_free ? (run_reg + CNT_W'(1)) : '0;
        end

        k_next = cmd.load ? '0 : (cmd.k_inc ? (k_reg + CNT_W'(1)) : k_reg);

        fcnt_next = fcnt_reg;
        if (cmd.load)
        begin
            fcnt_next = '0;
        end
        else if (cmd.cnt_step && blk_free)
        begin
            fcnt_next = fcnt_reg + IW'(1);
        end

        freed_next = cmd.load ? '0 : (free_hit ? (freed_reg + IW'(1)) : freed_reg);

        out_valid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            run_reg       <= '0;
            k_reg         <= '0;
            fcnt_reg      <= '0;
            freed_reg     <= '0;
            used_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg  <= in_op;
                cnt_reg <= cnt_clamp;
                n_reg   <= n_sel;
            end
            idx_reg       <= idx_next;
            run_reg       <= run_next;
            k_reg         <= k_next;
            fcnt_reg      <= fcnt_next;
            freed_reg     <= freed_next;
            rd_valid_reg  <= cmd.rd_issue;
            out_valid_reg <= out_valid_next;
            if (free_hit)
            begin
                used_reg[rd_idx_reg] <= 1'b0;
            end
            if (cmd.alloc)
            begin
                used_reg[addr] <= 1'b1;
            end
        end
    end

    // Payload registers and the owner memory carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg <= in_id;
        end
        if (cmd.alloc)
        begin
            owner_mem[addr] <= id_reg;
        end
        rd_data_reg <= owner_mem[addr];
        rd_idx_reg  <= addr;
        if (cmd.emit)
        begin
            out_status_reg <= cmd.code;
            out_block_reg  <= cmd.emit_blk ? BLK_W'(XW'(idx_reg)) : '0;
            out_freed_reg  <= freed_sat;
            out_last_reg   <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_freed_reg, out_block_reg, out_status_reg};

    `BOA_ASSERT_IMP(a_alloc_free, clk, rst_n, cmd.alloc, blk_free)
    `BOA_ASSERT_IMP(a_emit_room, clk, rst_n, cmd.emit, out_room)
    `BOA_ASSERT_IMP(a_release_only_on_free, clk, rst_n, free_hit, op_reg == OP_FREE)

endmodule
